// ===== hw/rtl/pott_pkg.sv =====
`default_nettype none
package pott_pkg;

  localparam int PERIODIC_SLOTS = 16;
  localparam int ONESHOT_SLOTS = 16;
  localparam int ID_BITS = 8;
  localparam int MAX_RESULTS = 32;
  localparam int QDEPTH = 2;

  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_ADD_P = 3'd1,
    OP_ADD_O = 3'd2,
    OP_DEL_P = 3'd3,
    OP_DEL_O = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    KIND_STATUS   = 2'd0,
    KIND_PERIODIC = 2'd1,
    KIND_ONESHOT  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_DUP       = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_ZERO      = 3'd4
  } status_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  id;
    logic [31:0] ival;
    logic [31:0] now;
  } cmd_t;

endpackage
`default_nettype wire

// ===== hw/rtl/pott_front.sv =====
`default_nettype none
module pott_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire logic [2:0]        opcode,
  input  wire logic [7:0]        timer_id,
  input  wire logic [31:0]       interval_seconds,
  input  wire logic [31:0]       now_seconds,
  output logic                   push_valid,
  input  wire logic              push_ready,
  output pott_pkg::cmd_t         push_cmd
);

  logic           fv;
  pott_pkg::cmd_t fcmd;
  logic           known;

  // opcodes past delete one-shot are accepted and dropped
  assign known = (opcode == pott_pkg::OP_TICK) || (opcode == pott_pkg::OP_ADD_P) ||
                 (opcode == pott_pkg::OP_ADD_O) || (opcode == pott_pkg::OP_DEL_P) ||
                 (opcode == pott_pkg::OP_DEL_O);

  assign item_ready = !fv || push_ready;
  assign push_valid = fv;
  assign push_cmd   = fcmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (item_valid && item_ready) begin
      fv <= known;
      fcmd.op   <= pott_pkg::op_t'(opcode);
      fcmd.id   <= timer_id;
      fcmd.ival <= interval_seconds;
      fcmd.now  <= now_seconds;
    end else if (push_ready) begin
      fv <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/pott_queue.sv =====
`default_nettype none
module pott_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           wr_valid,
  output logic                wr_ready,
  input  pott_pkg::cmd_t      wr_cmd,
  output logic                rd_valid,
  input  wire logic           rd_ready,
  output pott_pkg::cmd_t      rd_cmd
);

  localparam int D  = pott_pkg::QDEPTH;
  localparam int AW = (D > 1) ? $clog2(D) : 1;
  localparam int CW = $clog2(D + 1);

  pott_pkg::cmd_t mem [D];
  logic [AW-1:0]  wp;
  logic [AW-1:0]  rp;
  logic [CW-1:0]  cnt;
  logic           do_wr;
  logic           do_rd;

  assign wr_ready = (cnt != CW'(D));
  assign rd_valid = (cnt != '0);
  assign rd_cmd   = mem[rp];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_wr) begin
        mem[wp] <= wr_cmd;
        wp <= (wp == AW'(D - 1)) ? '0 : wp + 1'b1;
      end
      if (do_rd) begin
        rp <= (rp == AW'(D - 1)) ? '0 : rp + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt <= cnt + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/pott_back.sv =====
`default_nettype none
module pott_back #(
  parameter int PERIODIC_SLOTS = pott_pkg::PERIODIC_SLOTS,
  parameter int ONESHOT_SLOTS  = pott_pkg::ONESHOT_SLOTS,
  parameter int ID_BITS        = pott_pkg::ID_BITS
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cmd_valid,
  output logic                cmd_ready,
  input  pott_pkg::cmd_t      cmd,
  output logic                result_valid,
  input  wire logic           result_ready,
  output logic [1:0]          result_kind,
  output logic [7:0]          fired_id,
  output logic [2:0]          status,
  output logic [31:0]         fire_second,
  output logic                last
);

  localparam int P  = PERIODIC_SLOTS;
  localparam int O  = ONESHOT_SLOTS;
  localparam int PW = (P > 1) ? $clog2(P) : 1;
  localparam int OW = (O > 1) ? $clog2(O) : 1;
  localparam int SW = (PW > OW) ? PW : OW;
  localparam int NW = $clog2(pott_pkg::MAX_RESULTS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_ADD, S_ADD_DONE, S_DEL, S_STATUS,
    S_DIV, S_PSEL, S_PPICK, S_OSEL, S_OPICK, S_FLUSH
  } state_t;

  state_t state;

  logic [P-1:0]       p_valid;
  logic [31:0]        p_key [P];
  logic [ID_BITS-1:0] p_own [P];
  logic [P-1:0]       p_hit;
  logic [O-1:0]       o_valid;
  logic [31:0]        o_key [O];
  logic [ID_BITS-1:0] o_own [O];

  logic [31:0]        cur_sec;
  pott_pkg::op_t      c_op;
  logic [ID_BITS-1:0] c_id;
  logic [31:0]        c_key;
  logic [31:0]        c_now;
  logic               c_osel;
  logic               flag;
  logic               free_v;
  logic [SW-1:0]      free_i;
  logic [SW-1:0]      slot;
  logic [4:0]         bitn;
  logic [31:0]        rem;
  logic               best_v;
  logic [SW-1:0]      best_i;
  logic [31:0]        best_key;
  logic [ID_BITS-1:0] best_own;
  logic               pend_v;
  pott_pkg::kind_t    pend_kind;
  logic [ID_BITS-1:0] pend_own;
  logic [NW-1:0]      n;
  pott_pkg::status_t  st;
  logic               out_v;

  logic [PW-1:0]      pidx;
  logic [OW-1:0]      oidx;
  logic               s_v;
  logic [31:0]        s_key;
  logic [ID_BITS-1:0] s_own;
  logic               s_last;
  logic [32:0]        rem_sh;
  logic [32:0]        rem_nx;
  logic               can_load;
  logic               better;

  assign pidx     = slot[PW-1:0];
  assign oidx     = slot[OW-1:0];
  assign s_v      = c_osel ? o_valid[oidx] : p_valid[pidx];
  assign s_key    = c_osel ? o_key[oidx] : p_key[pidx];
  assign s_own    = c_osel ? o_own[oidx] : p_own[pidx];
  assign s_last   = c_osel ? (slot == SW'(O - 1)) : (slot == SW'(P - 1));
  assign rem_sh   = {rem, c_now[bitn]};
  assign rem_nx   = (rem_sh >= {1'b0, s_key}) ? rem_sh - {1'b0, s_key} : rem_sh;
  assign can_load = !out_v || result_ready;
  assign better   = !best_v || ({s_key, s_own} < {best_key, best_own});
  assign cmd_ready    = (state == S_IDLE);
  assign result_valid = out_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      p_valid <= '0;
      o_valid <= '0;
      cur_sec <= '0;
      out_v   <= 1'b0;
      pend_v  <= 1'b0;
    end else begin
      if (out_v && result_ready) begin
        out_v <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            c_op  <= cmd.op;
            c_id  <= ID_BITS'({{16{1'b0}}, cmd.id});
            c_key <= cmd.ival;
            c_now <= cmd.now;
            state <= S_START;
          end
        end
        S_START: begin
          slot   <= '0;
          flag   <= 1'b0;
          free_v <= 1'b0;
          c_osel <= (c_op == pott_pkg::OP_ADD_O) || (c_op == pott_pkg::OP_DEL_O);
          case (c_op)
            pott_pkg::OP_TICK: begin
              if (c_now == cur_sec) begin
                state <= S_IDLE;
              end else begin
                cur_sec <= c_now;
                n       <= '0;
                pend_v  <= 1'b0;
                bitn    <= 5'd31;
                rem     <= '0;
                p_hit   <= '0;
                state   <= S_DIV;
              end
            end
            pott_pkg::OP_ADD_P: begin
              if (c_key == '0) begin
                st    <= pott_pkg::ST_ZERO;
                state <= S_STATUS;
              end else begin
                state <= S_ADD;
              end
            end
            pott_pkg::OP_ADD_O: begin
              c_key <= cur_sec + c_key;
              state <= S_ADD;
            end
            default: begin
              state <= S_DEL;
            end
          endcase
        end
        S_ADD: begin
          if (s_v && s_key == c_key && s_own == c_id) begin
            flag <= 1'b1;
          end else if (!s_v && !free_v) begin
            free_v <= 1'b1;
            free_i <= slot;
          end
          if (s_last) begin
            state <= S_ADD_DONE;
          end else begin
            slot <= slot + 1'b1;
          end
        end
        S_ADD_DONE: begin
          if (flag) begin
            st <= pott_pkg::ST_DUP;
          end else if (!free_v) begin
            st <= pott_pkg::ST_FULL;
          end else begin
            st <= pott_pkg::ST_OK;
            if (c_osel) begin
              o_valid[free_i[OW-1:0]] <= 1'b1;
              o_key[free_i[OW-1:0]]   <= c_key;
              o_own[free_i[OW-1:0]]   <= c_id;
            end else begin
              p_valid[free_i[PW-1:0]] <= 1'b1;
              p_key[free_i[PW-1:0]]   <= c_key;
              p_own[free_i[PW-1:0]]   <= c_id;
            end
          end
          state <= S_STATUS;
        end
        S_DEL: begin
          if (s_v && s_own == c_id) begin
            flag <= 1'b1;
            if (c_osel) begin
              o_valid[oidx] <= 1'b0;
            end else begin
              p_valid[pidx] <= 1'b0;
            end
          end
          if (s_last) begin
            st    <= (flag || (s_v && s_own == c_id)) ? pott_pkg::ST_OK
                                                       : pott_pkg::ST_NOT_FOUND;
            state <= S_STATUS;
          end else begin
            slot <= slot + 1'b1;
          end
        end
        S_STATUS: begin
          if (can_load) begin
            out_v       <= 1'b1;
            result_kind <= pott_pkg::KIND_STATUS;
            fired_id    <= 8'({{8{1'b0}}, c_id});
            status      <= st;
            fire_second <= '0;
            last        <= 1'b1;
            state       <= S_IDLE;
          end
        end
        // bit-serial remainder of the new second by each period
        S_DIV: begin
          if (!s_v || s_key == '0 || bitn == 5'd0) begin
            p_hit[pidx] <= s_v && (s_key != '0) && (rem_nx == '0);
            rem  <= '0;
            bitn <= 5'd31;
            best_v <= 1'b0;
            if (s_last) begin
              slot  <= '0;
              state <= S_PSEL;
            end else begin
              slot <= slot + 1'b1;
            end
          end else begin
            rem  <= rem_nx[31:0];
            bitn <= bitn - 1'b1;
          end
        end
        S_PSEL: begin
          if (p_hit[pidx] && better) begin
            best_v   <= 1'b1;
            best_i   <= slot;
            best_key <= s_key;
            best_own <= s_own;
          end
          if (s_last) begin
            state <= S_PPICK;
          end else begin
            slot <= slot + 1'b1;
          end
        end
        S_PPICK: begin
          slot <= '0;
          if (!best_v || n == NW'(pott_pkg::MAX_RESULTS)) begin
            best_v <= 1'b0;
            c_osel <= 1'b1;
            state  <= S_OSEL;
          end else if (!pend_v || can_load) begin
            if (pend_v) begin
              out_v       <= 1'b1;
              result_kind <= pend_kind;
              fired_id    <= 8'({{8{1'b0}}, pend_own});
              status      <= pott_pkg::ST_OK;
              fire_second <= cur_sec;
              last        <= 1'b0;
            end
            pend_v    <= 1'b1;
            pend_kind <= pott_pkg::KIND_PERIODIC;
            pend_own  <= best_own;
            n         <= n + 1'b1;
            p_hit[best_i[PW-1:0]] <= 1'b0;
            best_v    <= 1'b0;
            state     <= S_PSEL;
          end
        end
        S_OSEL: begin
          if (s_v && s_key <= c_now && better) begin
            best_v   <= 1'b1;
            best_i   <= slot;
            best_key <= s_key;
            best_own <= s_own;
          end
          if (s_last) begin
            state <= S_OPICK;
          end else begin
            slot <= slot + 1'b1;
          end
        end
        S_OPICK: begin
          slot <= '0;
          if (!best_v || n == NW'(pott_pkg::MAX_RESULTS)) begin
            state <= S_FLUSH;
          end else if (!pend_v || can_load) begin
            if (pend_v) begin
              out_v       <= 1'b1;
              result_kind <= pend_kind;
              fired_id    <= 8'({{8{1'b0}}, pend_own});
              status      <= pott_pkg::ST_OK;
              fire_second <= cur_sec;
              last        <= 1'b0;
            end
            pend_v    <= 1'b1;
            pend_kind <= pott_pkg::KIND_ONESHOT;
            pend_own  <= best_own;
            n         <= n + 1'b1;
            o_valid[best_i[OW-1:0]] <= 1'b0;
            best_v    <= 1'b0;
            state     <= S_OSEL;
          end
        end
        S_FLUSH: begin
          if (!pend_v) begin
            state <= S_IDLE;
          end else if (can_load) begin
            out_v       <= 1'b1;
            result_kind <= pend_kind;
            fired_id    <= 8'({{8{1'b0}}, pend_own});
            status      <= pott_pkg::ST_OK;
            fire_second <= cur_sec;
            last        <= 1'b1;
            pend_v      <= 1'b0;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/periodic_and_oneshot_timer_table_unit.sv =====
`default_nettype none
// Timer table with a periodic and a one-shot table. A registered front stage takes commands
// and drops unknown opcodes, a two-entry queue feeds the back end, and the back end runs
// one command at a time over the tables, one slot per cycle in its add, delete and selection
// scans. Add and delete give one status beat. A tick that changes the second runs each
// valid periodic slot through the bit-serial remainder unit, then repeats an ordered
// selection scan of each table for each fire. Results leave through an output register;
// the tables start empty at reset.
module periodic_and_oneshot_timer_table_unit #(
  parameter int PERIODIC_SLOTS = pott_pkg::PERIODIC_SLOTS,
  parameter int ONESHOT_SLOTS  = pott_pkg::ONESHOT_SLOTS,
  parameter int ID_BITS        = pott_pkg::ID_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_ready,
  input  wire logic [2:0]  opcode,
  input  wire logic [7:0]  timer_id,
  input  wire logic [31:0] interval_seconds,
  input  wire logic [31:0] now_seconds,
  output logic             result_valid,
  input  wire logic        result_ready,
  output logic [1:0]       result_kind,
  output logic [7:0]       fired_id,
  output logic [2:0]       status,
  output logic [31:0]      fire_second,
  output logic             last
);

  logic           f_valid;
  logic           f_ready;
  pott_pkg::cmd_t f_cmd;
  logic           q_valid;
  logic           q_ready;
  pott_pkg::cmd_t q_cmd;

  pott_front u_front (
    .clk, .rst, .item_valid, .item_ready, .opcode, .timer_id,
    .interval_seconds, .now_seconds,
    .push_valid(f_valid), .push_ready(f_ready), .push_cmd(f_cmd)
  );

  pott_queue u_queue (
    .clk, .rst,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_cmd(f_cmd),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_cmd(q_cmd)
  );

  pott_back #(
    .PERIODIC_SLOTS(PERIODIC_SLOTS),
    .ONESHOT_SLOTS(ONESHOT_SLOTS),
    .ID_BITS(ID_BITS)
  ) u_back (
    .clk, .rst,
    .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
    .result_valid, .result_ready, .result_kind, .fired_id, .status,
    .fire_second, .last
  );

endmodule
`default_nettype wire

// ===== hw/rtl/pott_checker.sv =====
`default_nettype none
module pott_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        item_valid,
  input wire logic        item_ready,
  input wire logic [2:0]  opcode,
  input wire logic [7:0]  timer_id,
  input wire logic [31:0] interval_seconds,
  input wire logic [31:0] now_seconds,
  input wire logic        result_valid,
  input wire logic        result_ready,
  input wire logic [1:0]  result_kind,
  input wire logic [7:0]  fired_id,
  input wire logic [2:0]  status,
  input wire logic [31:0] fire_second,
  input wire logic        last
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(fired_id) && $stable(last))
    else $error("result changed while stalled");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_kind == pott_pkg::KIND_STATUS |-> last && fire_second == '0)
    else $error("status beat not final");

  a_fire_ok: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_kind != pott_pkg::KIND_STATUS |-> status == pott_pkg::ST_OK)
    else $error("fire beat with status");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_ready |=> item_valid && $stable(opcode) && $stable(timer_id) &&
    $stable(interval_seconds) && $stable(now_seconds))
    else $error("input beat changed while stalled");

endmodule

bind periodic_and_oneshot_timer_table_unit pott_checker u_chk (.*);
`default_nettype wire
